// ----- hdl/stable_min_priority_queue_assert.svh -----
// Assertion macros for the stable_min_priority_queue checker.
// Needs nothing else; included by the checker file.
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define SMPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smpq assertion failed");

// next-cycle implication, skipped while in reset
`define SMPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smpq assertion failed");

`endif

// ----- hdl/smpq_pkg.sv -----
// Shared constants, types and controller/datapath interface for the
// stable minimum-first priority queue. No dependencies.
`default_nettype none

package smpq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int TAG_BITS      = 16;
  localparam int IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_W      = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ENQUEUED = 2'd0;
  localparam status_t ST_DEQUEUED = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  typedef struct packed {
    logic accept;      // capture request, rewind pointer
    logic enq_write;   // store request at tail
    logic set_full;
    logic set_empty;
    logic step;        // one read/process step over the store
    logic shift_mode;  // step compacts instead of searching
    logic shift_init;  // point at entry after the best one
    logic deq_done;    // drop count, latch best as result
    logic load_out;    // move result into output register
  } smpq_cmd_t;

  typedef struct packed {
    logic req_deq;
    logic empty;
    logic full;
    logic step_done;
    logic out_busy;
  } smpq_sts_t;

endpackage

`default_nettype wire

// ----- hdl/smpq_ctrl.sv -----
// Sequencing state machine for the priority queue.
// Uses smpq_pkg; drives commands into smpq_dpath.
`default_nettype none

module smpq_ctrl
  import smpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire smpq_sts_t sts,
  output smpq_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (!sts.req_deq && sts.full) begin
          cmd.set_full = 1'b1;
          state_next   = S_FINISH;
        end else if (!sts.req_deq) begin
          cmd.enq_write = 1'b1;
          state_next    = S_FINISH;
        end else if (sts.empty) begin
          cmd.set_empty = 1'b1;
          state_next    = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.step_done) begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.step_done) begin
          cmd.deq_done = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.step       = 1'b1;
          cmd.shift_mode = 1'b1;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/smpq_dpath.sv -----
// Datapath: entry store, search and compaction pointers, best-entry
// registers and output register. Uses smpq_pkg; driven by smpq_ctrl.
`default_nettype none

module smpq_dpath
  import smpq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire smpq_cmd_t                cmd,
  output smpq_sts_t                     sts,
  input  wire logic                     req_type,
  input  wire logic [PRIORITY_BITS-1:0] entry_priority,
  input  wire logic [TAG_BITS-1:0]      entry_tag,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output status_t                       status,
  output logic [PRIORITY_BITS-1:0]      out_priority,
  output logic [TAG_BITS-1:0]           out_tag,
  output logic [CNT_W-1:0]              fill_count
);

  entry_t mem [QUEUE_DEPTH];

  logic                     req_deq;
  entry_t                   req_entry;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         rd_ptr;
  logic                     rd_valid;
  entry_t                   rd_data;
  logic [IDX_W-1:0]         rd_idx;
  logic                     best_have;
  entry_t                   best;
  logic [IDX_W-1:0]         best_idx;
  status_t                  res_status;
  entry_t                   res_entry;

  logic issue;
  logic take_best;
  logic shift_write;

  assign issue       = cmd.step && (rd_ptr < count);
  assign take_best   = cmd.step && !cmd.shift_mode && rd_valid &&
                       (!best_have || (rd_data.prio < best.prio));
  assign shift_write = cmd.step && cmd.shift_mode && rd_valid;

  assign sts.req_deq   = (req_deq == REQ_DEQUEUE);
  assign sts.empty     = (count == '0);
  assign sts.full      = (count == CNT_W'(QUEUE_DEPTH));
  assign sts.step_done = (rd_ptr == count) && !rd_valid;
  assign sts.out_busy  = out_valid && out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_ptr    <= '0;
      rd_valid  <= 1'b0;
      best_have <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      priority if (cmd.enq_write) begin
        count <= count + CNT_W'(1);
      end else if (cmd.deq_done) begin
        count <= count - CNT_W'(1);
      end

      priority if (cmd.accept) begin
        rd_ptr <= '0;
      end else if (cmd.shift_init) begin
        rd_ptr <= CNT_W'(best_idx) + CNT_W'(1);
      end else if (issue) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end

      rd_valid <= issue;

      priority if (cmd.accept) begin
        best_have <= 1'b0;
      end else if (take_best) begin
        best_have <= 1'b1;
      end

      priority if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // store: one read port, one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_ptr[IDX_W-1:0]];
    end
    if (cmd.enq_write) begin
      mem[count[IDX_W-1:0]] <= req_entry;
    end else if (shift_write) begin
      // close the gap: entry read from slot i lands in slot i-1
      mem[rd_idx - IDX_W'(1)] <= rd_data;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_deq        <= req_type;
      req_entry.prio <= entry_priority;
      req_entry.tag  <= entry_tag;
    end
    if (issue) begin
      rd_idx <= rd_ptr[IDX_W-1:0];
    end
    if (take_best) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
    priority if (cmd.enq_write) begin
      res_status <= ST_ENQUEUED;
      res_entry  <= '0;
    end else if (cmd.set_full) begin
      res_status <= ST_FULL;
      res_entry  <= '0;
    end else if (cmd.set_empty) begin
      res_status <= ST_EMPTY;
      res_entry  <= '0;
    end else if (cmd.deq_done) begin
      res_status <= ST_DEQUEUED;
      res_entry  <= best;
    end
    if (cmd.load_out) begin
      status       <= res_status;
      out_priority <= res_entry.prio;
      out_tag      <= res_entry.tag;
      fill_count   <= count;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/stable_min_priority_queue.sv -----
// Channel  Handshake             Payload
// in       in_valid / in_stall   req_type, entry_priority, entry_tag
// out      out_valid / out_stall status, out_priority, out_tag, fill_count
//
// Enqueue: the request is accepted in idle, written at the tail in
// decide, and its result is loaded in finish once the output is free.
// Dequeue: the single-read-port store is swept once to search for the
// best entry and again, from the slot after it, to compact.
// Next transaction is taken once the sequencer is back in idle, even
// while the previous result is still held by out_stall.
// Synchronous reset empties the queue; store contents are not cleared.
// Top level: joins smpq_ctrl and smpq_dpath. Uses smpq_pkg.
`default_nettype none

module stable_min_priority_queue
  import smpq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     req_type,
  input  wire logic [PRIORITY_BITS-1:0] entry_priority,
  input  wire logic [TAG_BITS-1:0]      entry_tag,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output status_t                       status,
  output logic [PRIORITY_BITS-1:0]      out_priority,
  output logic [TAG_BITS-1:0]           out_tag,
  output logic [CNT_W-1:0]              fill_count
);

  smpq_cmd_t cmd;
  smpq_sts_t sts;

  smpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  smpq_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (req_type),
    .entry_priority (entry_priority),
    .entry_tag      (entry_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_priority   (out_priority),
    .out_tag        (out_tag),
    .fill_count     (fill_count)
  );

endmodule

`default_nettype wire

// ----- hdl/smpq_checker.sv -----
// Port-level checks for stable_min_priority_queue, bound to the top level.
// Uses smpq_pkg and stable_min_priority_queue_assert.svh.
`default_nettype none

`include "stable_min_priority_queue_assert.svh"

module smpq_checker
  import smpq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [STATUS_W-1:0]      status,
  input wire logic [PRIORITY_BITS-1:0] out_priority,
  input wire logic [TAG_BITS-1:0]      out_tag,
  input wire logic [CNT_W-1:0]         fill_count
);

  `SMPQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `SMPQ_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(status) && $stable(out_priority) && $stable(out_tag) && $stable(fill_count))
  `SMPQ_ASSERT_NOW(a_count_range, clk, rst, out_valid, fill_count <= CNT_W'(QUEUE_DEPTH))
  `SMPQ_ASSERT_NOW(a_full_count, clk, rst, out_valid && (status == ST_FULL), fill_count == CNT_W'(QUEUE_DEPTH))
  `SMPQ_ASSERT_NOW(a_zero_payload, clk, rst, out_valid && (status != ST_DEQUEUED), (out_priority == '0) && (out_tag == '0))

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .out_priority (out_priority),
  .out_tag      (out_tag),
  .fill_count   (fill_count)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for stable_min_priority_queue: random and directed requests,
// results checked against a min-first, arrival-order-on-ties queue predictor.
// Depends on smpq_pkg and the RTL under hdl/.
`default_nettype none

module tb_top
  import smpq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                  st;
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
    logic [CNT_W-1:0]         fill;
  } queue_result_t;

  // Holds the predicted queue contents and the results still owed by the block.
  class smpq_scoreboard;
    entry_t        held_q[$];
    queue_result_t owed_q[$];
    int unsigned   errors = 0;

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_request(logic req, logic [PRIORITY_BITS-1:0] p,
                               logic [TAG_BITS-1:0] t);
      queue_result_t r;
      entry_t        e;
      int unsigned   best;
      int unsigned   k;
      r = '0;
      if (req == REQ_ENQUEUE) begin
        if (held_q.size() >= QUEUE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          e.prio = p;
          e.tag  = t;
          held_q.push_back(e);
          r.st = ST_ENQUEUED;
        end
      end else if (held_q.size() == 0) begin
        r.st = ST_EMPTY;
      end else begin
        // strict less-than keeps the earliest arrival on a tie
        best = 0;
        for (k = 1; k < held_q.size(); k++) begin
          if (held_q[k].prio < held_q[best].prio) best = k;
        end
        r.st   = ST_DEQUEUED;
        r.prio = held_q[best].prio;
        r.tag  = held_q[best].tag;
        held_q.delete(best);
      end
      r.fill = CNT_W'(held_q.size());
      owed_q.push_back(r);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      logic          bad;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: st=%0d pri=%h tag=%h fill=%0d",
                   got.st, got.prio, got.tag, got.fill);
        return;
      end
      want = owed_q.pop_front();
      bad  = (got.st !== want.st) || (got.prio !== want.prio) ||
             (got.tag !== want.tag) || (got.fill !== want.fill);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want st=%0d pri=%h tag=%h fill=%0d, got st=%0d pri=%h tag=%h fill=%0d",
                   want.st, want.prio, want.tag, want.fill,
                   got.st, got.prio, got.tag, got.fill);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     req_type = REQ_ENQUEUE;
  logic [PRIORITY_BITS-1:0] entry_priority = '0;
  logic [TAG_BITS-1:0]      entry_tag = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  status_t                  status;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [TAG_BITS-1:0]      out_tag;
  logic [CNT_W-1:0]         fill_count;

  smpq_scoreboard sb = new();

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req_cnt = 0;

  localparam logic [PRIORITY_BITS-1:0] DIR_PRIO [16] = '{
    16'hFFFF, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h5555, 16'hAAAA,
    16'h0001, 16'hFFFE, 16'h7FFF, 16'h8000, 16'h0000, 16'h00FF, 16'hFF00, 16'h8000
  };

  stable_min_priority_queue uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .entry_priority (entry_priority),
    .entry_tag      (entry_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_priority   (out_priority),
    .out_tag        (out_tag),
    .fill_count     (fill_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side: check accepted transactions, then pick the next stall value
  initial begin
    queue_result_t got;
    int unsigned   hold_left;
    int unsigned   hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.st   = status;
        got.prio = out_priority;
        got.tag  = out_tag;
        got.fill = fill_count;
        sb.check_result(got);
      end
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic offer(input logic req, input logic [PRIORITY_BITS-1:0] p,
                       input logic [TAG_BITS-1:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= req;
    entry_priority <= p;
    entry_tag      <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, p, t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // narrow ranges give plenty of equal priorities
  function automatic logic [PRIORITY_BITS-1:0] pick_priority();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return PRIORITY_BITS'($urandom_range(0, 7));
    if (r < 50) return '0;
    if (r < 55) return '1;
    return PRIORITY_BITS'($urandom);
  endfunction

  task automatic run_phase(input int unsigned items, input int unsigned tx_pct,
                           input int unsigned rx_pct);
    int unsigned done;
    int unsigned burst_len;
    int unsigned enq_pct;
    int unsigned k;
    logic        quiet;
    done = 0;
    while (done < items) begin
      burst_len = $urandom_range(10, 60);
      // bursts that lean to filling or draining walk the queue between empty and full
      case ($urandom_range(0, 2))
        0:       enq_pct = 80;
        1:       enq_pct = 25;
        default: enq_pct = 55;
      endcase
      quiet       = ($urandom_range(0, 3) == 0);
      tx_idle_pct = quiet ? 0 : tx_pct;
      rx_idle_pct <= quiet ? 0 : rx_pct;
      for (k = 0; k < burst_len && done < items; k++) begin
        offer(($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE,
              pick_priority(), TAG_BITS'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    int unsigned k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    offer(REQ_DEQUEUE, 16'h1234, 16'h4321);
    for (k = 0; k < 16; k++)
      offer(REQ_ENQUEUE, DIR_PRIO[k], {4'(k), 12'h000} ^ ~DIR_PRIO[k]);
    offer(REQ_ENQUEUE, 16'h0000, 16'hFFFF);
    for (k = 0; k < 7; k++)
      offer(REQ_DEQUEUE, 16'hFFFF, 16'h0000);
    wait_drained();

    run_phase(600, 24, 88);
    wait_drained();
    run_phase(600, 88, 24);
    wait_drained();

    // long receiver hold-off with the sender pushing hard
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req_cnt <= hold_req_cnt + 1;
    for (k = 0; k < 40; k++)
      offer(($urandom_range(0, 1) == 0) ? REQ_ENQUEUE : REQ_DEQUEUE,
            pick_priority(), TAG_BITS'($urandom));
    wait_drained();

    run_phase(560, 0, 0);
    wait_drained();
    repeat (48) @(posedge clk);

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_ctrl.sv
hdl/smpq_dpath.sv
hdl/stable_min_priority_queue.sv
hdl/smpq_checker.sv
sim/tb_top.sv
